// ===== sv/abm_pkg.sv =====
// abm_pkg: shared widths, codes, constants and state type for the altitude band monitor
// no dependencies; imported by altitude_band_monitor_top and tb_top

package abm_pkg;

  // field widths
  localparam int ALT_W     = 21;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int MISS_W    = 4;

  // input mode codes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ENTER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH5_ENTER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_RETURN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH5_EXIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_WIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_STEP     = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] HIGH_ENTER_RST  = 17'd220;
  localparam logic [CFG_W-1:0] HIGH5_ENTER_RST = 17'd520;
  localparam logic [CFG_W-1:0] LOW_RETURN_RST  = 17'd180;
  localparam logic [CFG_W-1:0] HIGH5_EXIT_RST  = 17'd480;
  localparam logic [CFG_W-1:0] OUTLIER_WIN_RST = 17'd500;
  localparam logic [CFG_W-1:0] DROP_STEP_RST   = 17'd300;

  // substitute altitude on a failed read, first-average limit, miss counter limits
  localparam logic signed [ALT_W-1:0] FAIL_ALT_CM    = 21'sd5000;
  localparam logic [ALT_W:0]          FIRST_LIMIT_CM = 22'd100;
  localparam logic [MISS_W-1:0]       MISS_MAX       = 4'd15;
  localparam logic [MISS_W-1:0]       MISS_LIMIT     = 4'd3;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SUM   = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_PUSH  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_CLASS = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

// ===== sv/altitude_band_monitor_top.sv =====
// altitude_band_monitor_top: grouped outlier-rejecting altitude filter with ground band monitor
// depends on abm_pkg
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------------
//  input     | in_valid / in_ready  | mode, altitude_cm, read_failed, set_ground_request,
//            |                      | speed_detect_request
//  result    | out_valid/out_ready  | filtered_valid, filtered_altitude_cm, event_*, is_*,
//            |                      | running
//  config    | cfg_write            | cfg_index, cfg_data
//
// an item that does not finish a group goes from S_IDLE to S_DONE, then into the result register
// a group-finishing sample goes through S_SUM (a second pass on the miss path), S_DIV,
//   S_PUSH, S_SCAN and S_CLASS to S_DONE, skipping states not needed; SW = 21 + clog2(GROUP_SIZE) + 1
// the shared restoring divider in S_DIV gives an SW-bit quotient, one quotient bit a cycle
// in_ready is high only while the sequencer is idle; a waiting result holds the last step
// reset is synchronous and loads the register defaults; no clearing pass is needed

module altitude_band_monitor_top
  import abm_pkg::*;
#(
  parameter int GROUP_SIZE    = 4,
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic signed [ALT_W-1:0]     altitude_cm,
  input  logic                        read_failed,
  input  logic                        set_ground_request,
  input  logic                        speed_detect_request,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        filtered_valid,
  output logic signed [ALT_W-1:0]     filtered_altitude_cm,
  output logic                        event_to_low,
  output logic                        event_to_high,
  output logic                        event_drop,
  output logic                        event_high5_reached,
  output logic                        is_high,
  output logic                        is_high5,
  output logic                        is_drop,
  output logic                        running,
  // configuration port
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  localparam int GIW  = $clog2(GROUP_SIZE);
  localparam int CNTW = $clog2(GROUP_SIZE + 1);
  localparam int HCW  = $clog2(HISTORY_DEPTH + 1);
  localparam int SW   = ALT_W + GIW + 1;
  localparam int HW   = ALT_W + 1 + $clog2(HISTORY_DEPTH) + 1;
  localparam int TW   = CFG_W + $clog2(HISTORY_DEPTH + 1);
  localparam int KW   = $clog2(SW + 1);

  // configuration registers
  logic [CFG_W-1:0] high_enter_cm, high5_enter_cm, low_return_cm;
  logic [CFG_W-1:0] high5_exit_cm, outlier_window_cm, drop_step_cm;

  // block state
  logic signed [ALT_W-1:0] samples [GROUP_SIZE];
  logic signed [ALT_W-1:0] history [HISTORY_DEPTH];
  logic [GIW-1:0]          group_index;
  logic signed [ALT_W-1:0] last_average;
  logic [MISS_W-1:0]       miss_count;
  logic [HCW-1:0]          history_count;
  logic signed [ALT_W-1:0] ground_ref;
  logic                    mark_high, mark_high5, mark_drop;
  logic                    pending_ground, speed_enabled;

  // sequencer
  state_t                  state;
  logic [KW-1:0]           step;
  logic                    plain;
  logic signed [SW-1:0]    sum;
  logic [CNTW-1:0]         cnt;
  logic [SW-1:0]           dvd;
  logic [CNTW:0]           rem;
  logic                    neg;
  logic                    classify;
  logic                    found;
  logic signed [HW-1:0]    hsum;

  // result of the current step
  logic                    res_valid;
  logic signed [ALT_W-1:0] res_avg;
  logic                    ev_low, ev_high, ev_drop, ev_h5;

  logic                    is_running;
  logic                    accept;
  logic signed [ALT_W-1:0] sample_in;
  logic [ALT_W:0]          last_abs;
  logic                    first_avg;
  logic signed [ALT_W-1:0] head;
  logic signed [ALT_W:0]   win_diff;
  logic [ALT_W:0]          win_abs;
  logic                    take;
  logic signed [SW-1:0]    sum_upd;
  logic [CNTW-1:0]         cnt_upd;
  logic [SW-1:0]           sum_abs;
  logic [MISS_W-1:0]       miss_sat;
  logic [CNTW:0]           rem_sh;
  logic                    fits;
  logic [CNTW:0]           rem_sub;
  logic [SW-1:0]           q_last;
  logic signed [ALT_W-1:0] avg_q;
  logic signed [ALT_W-1:0] h0, h1;
  logic signed [ALT_W:0]   gdiff;
  logic signed [ALT_W:0]   adiff;
  logic [ALT_W:0]          adiff_abs;
  logic                    adj_big;
  logic signed [HW-1:0]    hsum_add;
  logic [HW-1:0]           s_abs;
  logic [TW-1:0]           thr_high, thr_h5_enter, thr_low, thr_h5_exit;
  logic                    high_next, high5_next, drop_next;
  logic                    c_low, c_high, c_drop, c_h5;

  assign is_running = pending_ground | speed_enabled;
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid & in_ready;
  assign sample_in  = read_failed ? FAIL_ALT_CM : altitude_cm;

  // first-average test and outlier window on the head sample
  assign last_abs  = last_average[ALT_W-1] ? (ALT_W+1)'(-$signed({last_average[ALT_W-1], last_average}))
                                           : (ALT_W+1)'({last_average[ALT_W-1], last_average});
  assign first_avg = last_abs < FIRST_LIMIT_CM;
  assign head      = samples[0];
  assign win_diff  = $signed({last_average[ALT_W-1], last_average}) - $signed({head[ALT_W-1], head});
  assign win_abs   = win_diff[ALT_W] ? (ALT_W+1)'(-win_diff) : (ALT_W+1)'(win_diff);
  assign take      = plain | (win_abs < (ALT_W+1)'(outlier_window_cm));

  // shared accumulator
  assign sum_upd  = take ? sum + $signed({{(SW-ALT_W){head[ALT_W-1]}}, head}) : sum;
  assign cnt_upd  = take ? cnt + CNTW'(1) : cnt;
  assign sum_abs  = sum_upd[SW-1] ? SW'(-sum_upd) : SW'(sum_upd);
  assign miss_sat = (miss_count == MISS_MAX) ? MISS_MAX : miss_count + MISS_W'(1);

  // restoring divider step
  assign rem_sh  = {rem[CNTW-1:0], dvd[SW-1]};
  assign fits    = rem_sh >= {1'b0, cnt};
  assign rem_sub = rem_sh - {1'b0, cnt};
  assign q_last  = {dvd[SW-2:0], fits};
  assign avg_q   = neg ? -$signed(q_last[ALT_W-1:0]) : $signed(q_last[ALT_W-1:0]);

  // history scan: deviation from ground and adjacent step
  assign h0        = history[0];
  assign h1        = history[1];
  assign gdiff     = $signed({h0[ALT_W-1], h0}) - $signed({ground_ref[ALT_W-1], ground_ref});
  assign adiff     = $signed({h1[ALT_W-1], h1}) - $signed({h0[ALT_W-1], h0});
  assign adiff_abs = adiff[ALT_W] ? (ALT_W+1)'(-adiff) : (ALT_W+1)'(adiff);
  assign adj_big   = adiff_abs > (ALT_W+1)'(drop_step_cm);
  assign hsum_add  = hsum + $signed({{(HW-ALT_W-1){gdiff[ALT_W]}}, gdiff});

  // thresholds scaled by the history depth
  assign s_abs        = hsum[HW-1] ? HW'(-hsum) : HW'(hsum);
  assign thr_high     = TW'(high_enter_cm) * TW'(HISTORY_DEPTH);
  assign thr_h5_enter = TW'(high5_enter_cm) * TW'(HISTORY_DEPTH);
  assign thr_low      = TW'(low_return_cm) * TW'(HISTORY_DEPTH);
  assign thr_h5_exit  = TW'(high5_exit_cm) * TW'(HISTORY_DEPTH);

  // hysteresis classification and drop mark update
  always_comb begin
    high_next  = mark_high;
    high5_next = mark_high5;
    drop_next  = mark_drop;
    c_low      = 1'b0;
    c_high     = 1'b0;
    c_drop     = 1'b0;
    c_h5       = 1'b0;
    if (classify) begin
      if (mark_high) begin
        if (!mark_high5) begin
          if (s_abs > HW'(thr_h5_enter)) begin
            high5_next = 1'b1;
            c_h5       = 1'b1;
          end
          if (s_abs < HW'(thr_low)) begin
            high_next  = 1'b0;
            high5_next = 1'b0;
            c_low      = 1'b1;
          end
        end else if (s_abs < HW'(thr_h5_exit)) begin
          high_next = 1'b0;
          c_low     = 1'b1;
        end
      end else if (mark_high5) begin
        if (s_abs > HW'(thr_h5_enter)) begin
          high_next = 1'b1;
          c_high    = 1'b1;
        end
        if (s_abs < HW'(thr_low)) begin
          high5_next = 1'b0;
        end
      end else if (s_abs > HW'(thr_high)) begin
        high_next = 1'b1;
        c_high    = 1'b1;
      end
    end
    if (speed_enabled) begin
      if (found && !mark_drop) begin
        drop_next = 1'b1;
        c_drop    = 1'b1;
      end else if (!found && mark_drop) begin
        drop_next = 1'b0;
      end
    end
  end

  // sample and history shift lines, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && mode == MODE_SAMPLE && is_running) begin
      for (int i = 0; i < GROUP_SIZE - 1; i++) samples[i] <= samples[i+1];
      samples[GROUP_SIZE-1] <= sample_in;
    end else if (state == S_SUM) begin
      for (int i = 0; i < GROUP_SIZE - 1; i++) samples[i] <= samples[i+1];
      samples[GROUP_SIZE-1] <= samples[0];
    end
    if (state == S_PUSH) begin
      if (history_count == HCW'(HISTORY_DEPTH) && pending_ground) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) history[i] <= res_avg;
      end else begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) history[i] <= history[i+1];
        history[HISTORY_DEPTH-1] <= res_avg;
      end
    end else if (state == S_SCAN) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) history[i] <= history[i+1];
      history[HISTORY_DEPTH-1] <= history[0];
    end
  end

  // sequencer, control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      step              <= '0;
      high_enter_cm     <= HIGH_ENTER_RST;
      high5_enter_cm    <= HIGH5_ENTER_RST;
      low_return_cm     <= LOW_RETURN_RST;
      high5_exit_cm     <= HIGH5_EXIT_RST;
      outlier_window_cm <= OUTLIER_WIN_RST;
      drop_step_cm      <= DROP_STEP_RST;
      group_index       <= '0;
      last_average      <= '0;
      miss_count        <= '0;
      history_count     <= '0;
      ground_ref        <= '0;
      mark_high         <= 1'b0;
      mark_high5        <= 1'b0;
      mark_drop         <= 1'b0;
      pending_ground    <= 1'b0;
      speed_enabled     <= 1'b0;
      out_valid         <= 1'b0;
      res_valid         <= 1'b0;
      ev_low            <= 1'b0;
      ev_high           <= 1'b0;
      ev_drop           <= 1'b0;
      ev_h5             <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_write) begin
        case (cfg_index)
          REG_HIGH_ENTER:  high_enter_cm     <= cfg_data;
          REG_HIGH5_ENTER: high5_enter_cm    <= cfg_data;
          REG_LOW_RETURN:  low_return_cm     <= cfg_data;
          REG_HIGH5_EXIT:  high5_exit_cm     <= cfg_data;
          REG_OUTLIER_WIN: outlier_window_cm <= cfg_data;
          REG_DROP_STEP:   drop_step_cm      <= cfg_data;
          default: ;
        endcase
      end

      // result transfer
      if (out_valid && out_ready) out_valid <= 1'b0;

      case (state)
        // take an item and decode its mode
        S_IDLE: begin
          if (accept) begin
            res_valid <= 1'b0;
            res_avg   <= '0;
            ev_low    <= 1'b0;
            ev_high   <= 1'b0;
            ev_drop   <= 1'b0;
            ev_h5     <= 1'b0;
            state     <= S_DONE;
            case (mode)
              MODE_SAMPLE: begin
                if (is_running) begin
                  if (group_index == GIW'(GROUP_SIZE - 1)) begin
                    group_index <= '0;
                    sum         <= '0;
                    cnt         <= '0;
                    step        <= '0;
                    plain       <= first_avg;
                    state       <= S_SUM;
                  end else begin
                    group_index <= group_index + GIW'(1);
                  end
                end
              end
              MODE_START: begin
                if (!is_running) begin
                  group_index   <= '0;
                  history_count <= '0;
                end
                if (set_ground_request) pending_ground <= 1'b1;
                if (speed_detect_request) speed_enabled <= 1'b1;
              end
              MODE_STOP: begin
                pending_ground <= 1'b0;
                speed_enabled  <= 1'b0;
              end
              default: ;
            endcase
          end
        end

        // accumulate the group, one sample a cycle
        S_SUM: begin
          sum  <= sum_upd;
          cnt  <= cnt_upd;
          step <= step + KW'(1);
          if (step == KW'(GROUP_SIZE - 1)) begin
            step <= '0;
            if (plain || cnt_upd != '0) begin
              if (!plain) miss_count <= '0;
              dvd   <= sum_abs;
              neg   <= sum_upd[SW-1];
              rem   <= '0;
              state <= S_DIV;
            end else begin
              miss_count <= miss_sat;
              if (miss_sat > MISS_LIMIT) begin
                plain          <= 1'b1;
                pending_ground <= 1'b1;
                sum            <= '0;
                cnt            <= '0;
              end else begin
                res_avg   <= last_average;
                res_valid <= 1'b1;
                state     <= S_PUSH;
              end
            end
          end
        end

        // truncating divide of the sum by the kept count
        S_DIV: begin
          rem  <= fits ? rem_sub : rem_sh;
          dvd  <= q_last;
          step <= step + KW'(1);
          if (step == KW'(SW - 1)) begin
            step         <= '0;
            last_average <= avg_q;
            res_avg      <= avg_q;
            res_valid    <= 1'b1;
            state        <= S_PUSH;
          end
        end

        // enter the average into the history
        S_PUSH: begin
          if (history_count != HCW'(HISTORY_DEPTH)) begin
            history_count <= history_count + HCW'(1);
            state         <= S_DONE;
          end else begin
            if (pending_ground) begin
              pending_ground <= 1'b0;
              ground_ref     <= res_avg;
              ev_low         <= 1'b1;
              classify       <= 1'b0;
            end else begin
              classify <= 1'b1;
            end
            hsum  <= '0;
            found <= 1'b0;
            step  <= '0;
            state <= S_SCAN;
          end
        end

        // walk the history: deviation sum and adjacent steps
        S_SCAN: begin
          hsum <= hsum_add;
          step <= step + KW'(1);
          if (step != KW'(HISTORY_DEPTH - 1) && adj_big) found <= 1'b1;
          if (step == KW'(HISTORY_DEPTH - 1)) begin
            step  <= '0;
            state <= S_CLASS;
          end
        end

        // update the marks
        S_CLASS: begin
          mark_high  <= high_next;
          mark_high5 <= high5_next;
          mark_drop  <= drop_next;
          ev_low     <= ev_low | c_low;
          ev_high    <= c_high;
          ev_drop    <= c_drop;
          ev_h5      <= c_h5;
          state      <= S_DONE;
        end

        // load the result register once it is free
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            filtered_valid       <= res_valid;
            filtered_altitude_cm <= res_avg;
            event_to_low         <= ev_low;
            event_to_high        <= ev_high;
            event_drop           <= ev_drop;
            event_high5_reached  <= ev_h5;
            is_high              <= mark_high;
            is_high5             <= mark_high5;
            is_drop              <= mark_drop;
            running              <= is_running;
            state                <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_hist_bound: assert property (@(posedge clk) disable iff (rst)
    history_count <= HCW'(HISTORY_DEPTH))
    else $error("history count beyond depth");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt != '0)
    else $error("divide by zero count");

  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !filtered_valid |-> filtered_altitude_cm == '0)
    else $error("average nonzero without a finished group");

  a_drop_speed: assert property (@(posedge clk) disable iff (rst)
    $rose(mark_drop) |-> $past(speed_enabled))
    else $error("drop mark set with speed detection off");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("sequencer idle right after a transfer");

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for altitude_band_monitor_top, with its own band predictor
// depends on abm_pkg and altitude_band_monitor_top; needs no other file

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import abm_pkg::*;

  localparam int GROUP_LEN = 4;
  localparam int HIST_LEN  = 4;

  // mode code the block treats as idle
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  // behavior constants of the monitor
  localparam longint FAILED_READ_CM  = 5000;
  localparam longint FIRST_AVG_LIMIT = 100;
  localparam int unsigned MISS_SATURATE = 15;
  localparam int unsigned MISS_TRIGGER  = 3;
  localparam longint ALT_MAX = 1048575;
  localparam longint ALT_MIN = -1048576;

  // run control
  localparam int unsigned ITEM_GOAL    = 1400;
  localparam int          PHASES       = 6;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int          TAIL_CYCLES  = 64;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [ALT_W-1:0] altitude;
    logic                    failed;
    logic                    ground_req;
    logic                    speed_req;
  } alt_item_t;

  typedef struct packed {
    logic                    avg_valid;
    logic signed [ALT_W-1:0] avg_cm;
    logic                    to_low;
    logic                    to_high;
    logic                    drop_seen;
    logic                    high5_seen;
    logic                    high_now;
    logic                    high5_now;
    logic                    drop_now;
    logic                    active;
  } band_report_t;

  // predicts the band report of every transfer and checks the block's reports in order
  class band_scoreboard;
    longint      thresh [6];
    longint      group_buf [GROUP_LEN];
    int unsigned group_pos;
    longint      last_avg;
    int unsigned empty_groups;
    longint      history [HIST_LEN];
    int unsigned history_fill;
    longint      ground_cm;
    bit          high_mark, high5_mark, drop_mark, ground_pending, speed_on;

    band_report_t expected_reports [$];
    int unsigned  mismatch_count, orphan_count, result_count, item_count, active_items;
    int unsigned  average_count, capture_count, high_count, high5_count, drop_count;

    function new();
      thresh[REG_HIGH_ENTER]  = 220;
      thresh[REG_HIGH5_ENTER] = 520;
      thresh[REG_LOW_RETURN]  = 180;
      thresh[REG_HIGH5_EXIT]  = 480;
      thresh[REG_OUTLIER_WIN] = 500;
      thresh[REG_DROP_STEP]   = 300;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      thresh[idx] = longint'(value);
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // outlier-rejecting group mean, with the miss counter fallback
    function longint group_average();
      longint total;
      longint kept;
      total = 0;
      kept  = 0;
      if (magnitude(last_avg) < FIRST_AVG_LIMIT) begin
        foreach (group_buf[i]) total += group_buf[i];
        last_avg = total / GROUP_LEN;
        return last_avg;
      end
      foreach (group_buf[i]) begin
        if (magnitude(last_avg - group_buf[i]) < thresh[REG_OUTLIER_WIN]) begin
          total += group_buf[i];
          kept++;
        end
      end
      if (kept != 0) begin
        last_avg     = total / kept;
        empty_groups = 0;
        return last_avg;
      end
      if (empty_groups < MISS_SATURATE) empty_groups++;
      if (empty_groups > MISS_TRIGGER) begin
        total = 0;
        foreach (group_buf[i]) total += group_buf[i];
        last_avg       = total / GROUP_LEN;
        ground_pending = 1'b1;
      end
      return last_avg;
    endfunction

    // history shift, ground capture, hysteresis bands and drop detection
    function void push_average(longint avg, inout band_report_t rep);
      longint dev;
      bit     step_found;
      dev        = 0;
      step_found = 1'b0;
      if (history_fill < HIST_LEN) begin
        history[history_fill] = avg;
        history_fill++;
        return;
      end
      for (int i = 0; i < HIST_LEN - 1; i++) history[i] = history[i + 1];
      history[HIST_LEN - 1] = avg;

      if (ground_pending) begin
        ground_pending = 1'b0;
        ground_cm      = avg;
        rep.to_low     = 1'b1;
        capture_count++;
        foreach (history[i]) history[i] = avg;
      end else begin
        foreach (history[i]) dev += history[i] - ground_cm;
        dev = magnitude(dev);
        if (high_mark) begin
          if (!high5_mark) begin
            if (dev > thresh[REG_HIGH5_ENTER] * HIST_LEN) begin
              high5_mark     = 1'b1;
              rep.high5_seen = 1'b1;
            end
            if (dev < thresh[REG_LOW_RETURN] * HIST_LEN) begin
              high_mark  = 1'b0;
              high5_mark = 1'b0;
              rep.to_low = 1'b1;
            end
          end else if (dev < thresh[REG_HIGH5_EXIT] * HIST_LEN) begin
            high_mark  = 1'b0;
            rep.to_low = 1'b1;
          end
        end else if (high5_mark) begin
          if (dev > thresh[REG_HIGH5_ENTER] * HIST_LEN) begin
            high_mark   = 1'b1;
            rep.to_high = 1'b1;
          end
          if (dev < thresh[REG_LOW_RETURN] * HIST_LEN) high5_mark = 1'b0;
        end else if (dev > thresh[REG_HIGH_ENTER] * HIST_LEN) begin
          high_mark   = 1'b1;
          rep.to_high = 1'b1;
        end
      end

      if (speed_on) begin
        for (int i = 0; i < HIST_LEN - 1; i++) begin
          if (magnitude(history[i + 1] - history[i]) > thresh[REG_DROP_STEP]) step_found = 1'b1;
        end
        if (step_found && !drop_mark) begin
          drop_mark     = 1'b1;
          rep.drop_seen = 1'b1;
        end else if (!step_found && drop_mark) begin
          drop_mark = 1'b0;
        end
      end
    endfunction

    // one accepted input transfer: advance the state, queue the expected report
    function void note_item(alt_item_t it);
      band_report_t rep;
      longint       reading;
      longint       avg;
      bit           was_running;
      rep         = '0;
      was_running = ground_pending || speed_on;
      item_count++;
      case (it.mode)
        MODE_SAMPLE: begin
          if (was_running) begin
            active_items++;
            reading = it.failed ? FAILED_READ_CM : longint'($signed(it.altitude));
            if (group_pos >= GROUP_LEN) group_pos = 0;
            group_buf[group_pos] = reading;
            if (group_pos == GROUP_LEN - 1) begin
              avg           = group_average();
              rep.avg_valid = 1'b1;
              rep.avg_cm    = avg[ALT_W-1:0];
              average_count++;
              push_average(avg, rep);
              group_pos = 0;
            end else begin
              group_pos++;
            end
          end
        end
        MODE_START: begin
          active_items++;
          if (!was_running) begin
            foreach (group_buf[i]) group_buf[i] = 0;
            foreach (history[i]) history[i] = 0;
            group_pos    = 0;
            history_fill = 0;
          end
          if (it.ground_req) ground_pending = 1'b1;
          if (it.speed_req) speed_on = 1'b1;
        end
        MODE_STOP: begin
          if (was_running) active_items++;
          ground_pending = 1'b0;
          speed_on       = 1'b0;
        end
        default: ;
      endcase
      rep.high_now  = high_mark;
      rep.high5_now = high5_mark;
      rep.drop_now  = drop_mark;
      rep.active    = ground_pending || speed_on;
      if (rep.to_high) high_count++;
      if (rep.high5_seen) high5_count++;
      if (rep.drop_seen) drop_count++;
      expected_reports.push_back(rep);
    endfunction

    function void check_field(string field, longint want, longint got);
      if (want != got) begin
        mismatch_count++;
        if (mismatch_count + orphan_count <= REPORT_LIMIT) begin
          $display("mismatch on report %0d, %s: expected %0d, got %0d",
                   result_count, field, want, got);
        end
      end
    endfunction

    // one accepted result transfer against the oldest expectation
    function void check_result(band_report_t got);
      band_report_t want;
      result_count++;
      if (expected_reports.size() == 0) begin
        orphan_count++;
        if (mismatch_count + orphan_count <= REPORT_LIMIT) begin
          $display("report %0d arrived with nothing expected", result_count);
        end
        return;
      end
      want = expected_reports.pop_front();
      check_field("filtered_valid", want.avg_valid, got.avg_valid);
      check_field("filtered_altitude_cm", longint'($signed(want.avg_cm)),
                  longint'($signed(got.avg_cm)));
      check_field("event_to_low", want.to_low, got.to_low);
      check_field("event_to_high", want.to_high, got.to_high);
      check_field("event_drop", want.drop_seen, got.drop_seen);
      check_field("event_high5_reached", want.high5_seen, got.high5_seen);
      check_field("is_high", want.high_now, got.high_now);
      check_field("is_high5", want.high5_now, got.high5_now);
      check_field("is_drop", want.drop_now, got.drop_now);
      check_field("running", want.active, got.active);
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              mode;
  logic signed [ALT_W-1:0] altitude_cm;
  logic                    read_failed;
  logic                    set_ground_request;
  logic                    speed_detect_request;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    filtered_valid;
  logic signed [ALT_W-1:0] filtered_altitude_cm;
  logic                    event_to_low;
  logic                    event_to_high;
  logic                    event_drop;
  logic                    event_high5_reached;
  logic                    is_high;
  logic                    is_high5;
  logic                    is_drop;
  logic                    running;
  logic                    cfg_write;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  band_scoreboard sb;
  int unsigned    burst_left   = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    rx_left      = 0;
  int unsigned    rx_style     = 0;
  int unsigned    rx_tick      = 0;

  altitude_band_monitor_top #(
    .GROUP_SIZE    (GROUP_LEN),
    .HISTORY_DEPTH (HIST_LEN)
  ) i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .mode                 (mode),
    .altitude_cm          (altitude_cm),
    .read_failed          (read_failed),
    .set_ground_request   (set_ground_request),
    .speed_detect_request (speed_detect_request),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .filtered_valid       (filtered_valid),
    .filtered_altitude_cm (filtered_altitude_cm),
    .event_to_low         (event_to_low),
    .event_to_high        (event_to_high),
    .event_drop           (event_drop),
    .event_high5_reached  (event_high5_reached),
    .is_high              (is_high),
    .is_high5             (is_high5),
    .is_drop              (is_drop),
    .running              (running),
    .cfg_write            (cfg_write),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stalls, switching to a randomly chosen style whenever the rx_left countdown runs out
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_style <= $urandom_range(0, 3);
      rx_left  <= $urandom_range(50, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 2) != 0);
      2:       out_ready <= ((rx_tick % 5) < 2);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // transfer monitor on both channels
  always @(posedge clk) begin
    alt_item_t    item;
    band_report_t seen;
    if (!rst) begin
      if (in_valid && in_ready) begin
        item.mode       = mode;
        item.altitude   = altitude_cm;
        item.failed     = read_failed;
        item.ground_req = set_ground_request;
        item.speed_req  = speed_detect_request;
        sb.note_item(item);
      end
      if (out_valid && out_ready) begin
        seen.avg_valid  = filtered_valid;
        seen.avg_cm     = filtered_altitude_cm;
        seen.to_low     = event_to_low;
        seen.to_high    = event_to_high;
        seen.drop_seen  = event_drop;
        seen.high5_seen = event_high5_reached;
        seen.high_now   = is_high;
        seen.high5_now  = is_high5;
        seen.drop_now   = is_drop;
        seen.active     = running;
        sb.check_result(seen);
      end
    end
  end

  // cycles without any transfer or register write
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("no transfer for %0d cycles", QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic longint rand_alt();
    return longint'($signed(ALT_W'($urandom)));
  endfunction

  // one input transfer, with sender gaps between bursts
  task automatic send_item(input logic [1:0] m, input longint alt, input bit failed,
                           input bit gnd_req, input bit spd_req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid             <= 1'b1;
    mode                 <= m;
    altitude_cm          <= alt[ALT_W-1:0];
    read_failed          <= failed;
    set_ground_request   <= gnd_req;
    speed_detect_request <= spd_req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic noise_item();
    send_item(2'($urandom_range(0, 3)), rand_alt(), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // stop sending and wait until every report has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    sb.write_reg(idx, value[CFG_W-1:0]);
    @(posedge clk);
  endtask

  task automatic program_thresholds(input int unsigned he, input int unsigned h5e,
                                    input int unsigned lr, input int unsigned h5x,
                                    input int unsigned win, input int unsigned drop);
    write_reg(REG_HIGH_ENTER, he);
    write_reg(REG_HIGH5_ENTER, h5e);
    write_reg(REG_LOW_RETURN, lr);
    write_reg(REG_HIGH5_EXIT, h5x);
    write_reg(REG_OUTLIER_WIN, win);
    write_reg(REG_DROP_STEP, drop);
    cfg_write <= 1'b0;
  endtask

  // field extremes, every mode, ignored samples, a plain first average, an empty group
  task automatic run_directed();
    send_item(MODE_SAMPLE, ALT_MAX, 1'b0, 1'b1, 1'b1);
    send_item(MODE_IGNORED, ALT_MIN, 1'b1, 1'b1, 1'b1);
    send_item(MODE_STOP, 0, 1'b0, 1'b0, 1'b0);
    send_item(MODE_START, -1, 1'b0, 1'b0, 1'b0);
    send_item(MODE_START, 0, 1'b0, 1'b1, 1'b1);
    send_item(MODE_SAMPLE, -1000000, 1'b0, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, 1000000, 1'b0, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, 0, 1'b1, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, ALT_MAX, 1'b0, 1'b0, 1'b0);
    repeat (4) send_item(MODE_SAMPLE, ALT_MIN, 1'b0, 1'b0, 1'b0);
    send_item(MODE_START, 0, 1'b0, 1'b0, 1'b1);
    send_item(MODE_SAMPLE, 263300, 1'b0, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, 263450, 1'b0, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, 263300, 1'b1, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, 263393, 1'b0, 1'b0, 1'b0);
    send_item(MODE_IGNORED, 0, 1'b0, 1'b0, 1'b0);
    send_item(MODE_STOP, 0, 1'b0, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, 123, 1'b1, 1'b0, 1'b0);
  endtask

  // start, then groups of noisy readings around a level profile with climbs and jumps
  task automatic fly_session();
    longint      base;
    longint      offset;
    longint      level;
    longint      reading;
    int unsigned groups;
    int unsigned hold;
    int unsigned pick;
    bit          gnd;
    bit          spd;
    base = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 160)) - 80
                                       : longint'($urandom_range(0, 1800000)) - 900000;
    if ($urandom_range(0, 3) == 0) send_item(MODE_STOP, rand_alt(), 1'b0, 1'b0, 1'b0);
    gnd = ($urandom_range(0, 4) != 0);
    spd = ($urandom_range(0, 4) != 0) || !gnd;
    send_item(MODE_START, rand_alt(), 1'($urandom), gnd, spd);
    groups = $urandom_range(6, 24);
    offset = 0;
    hold   = 0;
    repeat (groups) begin
      // level profile
      if (hold != 0) begin
        hold--;
      end else begin
        hold = $urandom_range(0, 5);
        case ($urandom_range(0, 7))
          0, 1: offset = longint'($urandom_range(0, 1400));
          2:    offset = -longint'($urandom_range(0, 1400));
          3: begin
            if ($urandom_range(0, 1) == 0) offset += longint'($urandom_range(1500, 40000));
            else offset -= longint'($urandom_range(1500, 40000));
            hold = $urandom_range(3, 6);
          end
          4:       offset = 0;
          default: ;
        endcase
      end
      level = base + offset;
      repeat (GROUP_LEN) begin
        if ($urandom_range(0, 24) == 0) noise_item();
        pick = $urandom_range(0, 19);
        if (pick == 1) reading = level + longint'($urandom_range(600, 200000));
        else if (pick == 2) reading = level - longint'($urandom_range(600, 200000));
        else reading = level + longint'($urandom_range(0, 120)) - 60;
        if (reading > ALT_MAX) reading = ALT_MAX;
        if (reading < ALT_MIN) reading = ALT_MIN;
        send_item(MODE_SAMPLE, reading, pick == 0, 1'($urandom), 1'($urandom));
      end
    end
    if ($urandom_range(0, 1) == 0) send_item(MODE_STOP, rand_alt(), 1'b0, 1'b0, 1'b0);
  endtask

  // main sequence
  initial begin
    int          phase;
    int unsigned target;
    sb = new();
    rst                  <= 1'b1;
    in_valid             <= 1'b0;
    mode                 <= MODE_SAMPLE;
    altitude_cm          <= '0;
    read_failed          <= 1'b0;
    set_ground_request   <= 1'b0;
    speed_detect_request <= 1'b0;
    cfg_write            <= 1'b0;
    cfg_index            <= REG_HIGH_ENTER;
    cfg_data             <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    // random flights under several threshold settings, reset values first
    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       ;
        1:       program_thresholds(0, 0, 0, 0, 0, 0);
        2:       program_thresholds(100000, 100000, 100000, 100000, 100000, 100000);
        3, 4:    program_thresholds($urandom_range(100, 900), $urandom_range(300, 1500),
                                    $urandom_range(0, 400), $urandom_range(200, 1200),
                                    $urandom_range(150, 3000), $urandom_range(100, 1500));
        default: program_thresholds(220, 520, 180, 480, 500, 300);
      endcase
      target = ITEM_GOAL * (phase + 1) / PHASES;
      while (sb.active_items < target) begin
        if ($urandom_range(0, 7) == 0) noise_item();
        else fly_session();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d input transfers (%0d acting), %0d reports checked, %0d threshold settings",
             sb.item_count, sb.active_items, sb.result_count, PHASES);
    $display("%0d averages, %0d ground captures, %0d to high, %0d high5 reached, %0d drops",
             sb.average_count, sb.capture_count, sb.high_count, sb.high5_count,
             sb.drop_count);
    if (sb.mismatch_count == 0 && sb.orphan_count == 0 &&
        sb.expected_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/abm_pkg.sv
sv/altitude_band_monitor_top.sv
dv/tb_top.sv
